[rtl/core/krt_pkg.sv]
package krt_pkg;

  localparam int ID_W      = 32;
  localparam int TAG_W     = 64;
  localparam int AGE_W     = 8;
  localparam int MARKS_W   = 16;
  localparam int COUNT_W   = 7;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;
  localparam int S_TDATA_W = ID_W + TAG_W + AGE_W + MARKS_W;
  localparam int M_TDATA_W = 128;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_LIST   = 3'd1,
    OP_SEARCH = 3'd2,
    OP_UPDATE = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_LIST,
    ST_SCAN,
    ST_SHIFT,
    ST_EMIT
  } state_t;

endpackage

[rtl/core/keyed_record_table_unit.sv]
// Channel  Dir  Handshake            Payload
// s        in   s_tvalid/s_tready    s_tuser operation, s_tdata request fields
// m        out  m_tvalid/m_tready    m_tuser status, m_tdata record, m_tlast
//
// One record memory, one read and one write per cycle, read data registered.
// Add writes in ST_START unless full, then a registered result; search and update
// compare one entry per cycle in ST_SCAN; delete runs the scan on into
// compaction in ST_SHIFT, one entry moved per cycle; list emits one record per
// cycle unless m stalls. rst clears the record count and control state, not memory.
// A stalled m side holds emission; the next request is taken while a result waits.
module keyed_record_table_unit #(
  parameter int CAPACITY   = 64,
  parameter int NAME_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // key_id[31:0], name_tag[95:32], age_value[103:96], marks_value[119:104]
  input  logic [krt_pkg::S_TDATA_W-1:0] s_tdata,
  // operation[2:0]
  input  logic [krt_pkg::OP_W-1:0]      s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // rec_id[31:0], rec_name[95:32], rec_age[103:96], rec_marks[119:104],
  // count_now[126:120], zero[127]
  output logic [krt_pkg::M_TDATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [krt_pkg::STATUS_W-1:0]  m_tuser,
  output logic                          m_tlast
);
  import krt_pkg::*;

  localparam int NAME_W = 8 * NAME_BYTES;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [NAME_W-1:0]  name;
    logic [AGE_W-1:0]   age;
    logic [MARKS_W-1:0] marks;
  } rec_t;

  rec_t mem [CAPACITY];
  rec_t rdata;

  state_t              state, state_next;
  op_t                 op;
  rec_t                in_rec;
  logic [COUNT_W-1:0]  cnt, cnt_next;
  logic [COUNT_W-1:0]  ptr, ptr_next;
  logic [IDX_W-1:0]    ppos, ppos_next;
  logic                pv, pv_next;
  rec_t                hrec, hrec_next;
  status_t             res_status, res_status_next;

  logic                re, we;
  logic [IDX_W-1:0]    raddr, waddr;
  rec_t                wdata;

  logic                out_load;
  status_t             load_status;
  rec_t                load_rec;
  logic                load_last;

  logic [ID_W-1:0]     out_id;
  logic [TAG_W-1:0]    out_name;
  logic [AGE_W-1:0]    out_age;
  logic [MARKS_W-1:0]  out_marks;
  logic [COUNT_W-1:0]  out_count;
  status_t             out_status;
  logic                out_last;

  logic                out_free;
  logic                s_take;
  logic                at_end;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign s_take   = s_tvalid && s_tready;
  assign at_end   = ((COUNT_W'(ppos) + COUNT_W'(1)) == cnt);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    ptr_next        = ptr;
    ppos_next       = ppos;
    pv_next         = pv;
    hrec_next       = hrec;
    res_status_next = res_status;
    re              = 1'b0;
    raddr           = ptr[IDX_W-1:0];
    we              = 1'b0;
    waddr           = ppos;
    wdata           = rdata;
    out_load        = 1'b0;
    load_status     = STAT_OK;
    load_rec        = rdata;
    load_last       = 1'b1;

    case (state)
      ST_IDLE: begin
        if (s_take) begin
          state_next = ST_START;
        end
      end

      ST_START: begin
        ptr_next = '0;
        pv_next  = 1'b0;
        case (op)
          OP_ADD: begin
            state_next = ST_EMIT;
            if (cnt >= COUNT_W'(CAPACITY)) begin
              res_status_next = STAT_FULL;
            end else begin
              res_status_next = STAT_OK;
              we              = 1'b1;
              waddr           = cnt[IDX_W-1:0];
              wdata           = in_rec;
              hrec_next       = in_rec;
              cnt_next        = cnt + COUNT_W'(1);
            end
          end
          OP_LIST: begin
            if (cnt == '0) begin
              res_status_next = STAT_EMPTY;
              state_next      = ST_EMIT;
            end else begin
              state_next = ST_LIST;
            end
          end
          OP_SEARCH, OP_UPDATE, OP_DELETE: begin
            if (cnt == '0) begin
              res_status_next = STAT_NOT_FOUND;
              state_next      = ST_EMIT;
            end else begin
              state_next = ST_SCAN;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_LIST: begin
        if (!pv || out_free) begin
          if (pv) begin
            out_load  = 1'b1;
            load_rec  = rdata;
            load_last = at_end;
            if (at_end) begin
              state_next = ST_IDLE;
            end
          end
          if (ptr < cnt) begin
            re        = 1'b1;
            ptr_next  = ptr + COUNT_W'(1);
            ppos_next = ptr[IDX_W-1:0];
            pv_next   = 1'b1;
          end else begin
            pv_next = 1'b0;
          end
        end
      end

      ST_SCAN: begin
        if (ptr < cnt) begin
          re        = 1'b1;
          ptr_next  = ptr + COUNT_W'(1);
          ppos_next = ptr[IDX_W-1:0];
          pv_next   = 1'b1;
        end else begin
          pv_next = 1'b0;
        end
        if (pv) begin
          if (rdata.id == in_rec.id) begin
            res_status_next = STAT_OK;
            hrec_next       = rdata;
            case (op)
              OP_UPDATE: begin
                hrec_next.marks = in_rec.marks;
                wdata.marks     = in_rec.marks;
                we              = 1'b1;
                waddr           = ppos;
                state_next      = ST_EMIT;
              end
              OP_DELETE: begin
                state_next = ST_SHIFT;
              end
              default: begin
                state_next = ST_EMIT;
              end
            endcase
          end else if (at_end) begin
            res_status_next = STAT_NOT_FOUND;
            state_next      = ST_EMIT;
          end
        end
      end

      ST_SHIFT: begin
        if (pv) begin
          we    = 1'b1;
          waddr = ppos - IDX_W'(1);
          wdata = rdata;
          if (ptr < cnt) begin
            re        = 1'b1;
            ptr_next  = ptr + COUNT_W'(1);
            ppos_next = ptr[IDX_W-1:0];
            pv_next   = 1'b1;
          end else begin
            pv_next = 1'b0;
          end
        end else begin
          cnt_next   = cnt - COUNT_W'(1);
          state_next = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          load_status = res_status;
          load_rec    = (res_status == STAT_OK) ? hrec : '0;
          state_next  = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      pv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pv    <= pv_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    ppos       <= ppos_next;
    hrec       <= hrec_next;
    res_status <= res_status_next;
    if (s_take) begin
      op           <= op_t'(s_tuser);
      in_rec.id    <= s_tdata[0 +: ID_W];
      in_rec.name  <= s_tdata[ID_W +: NAME_W];
      in_rec.age   <= s_tdata[ID_W+TAG_W +: AGE_W];
      in_rec.marks <= s_tdata[ID_W+TAG_W+AGE_W +: MARKS_W];
    end
    if (out_load) begin
      out_id     <= load_rec.id;
      out_name   <= TAG_W'(load_rec.name);
      out_age    <= load_rec.age;
      out_marks  <= load_rec.marks;
      out_count  <= cnt;
      out_status <= load_status;
      out_last   <= load_last;
    end
  end

  assign m_tdata = {1'b0, out_count, out_marks, out_age, out_name, out_id};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

endmodule

[rtl/core/krt_checker.sv]
module krt_checker #(
  parameter int CAPACITY = 64
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [krt_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [krt_pkg::STATUS_W-1:0]  m_tuser,
  input logic                          m_tlast
);
  import krt_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // status results are single and carry no record
  a_blank: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STAT_OK) |-> m_tlast && (m_tdata[119:0] == '0))
    else $error("status result not blank or not last");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STAT_FULL) |-> (m_tdata[126:120] == COUNT_W'(CAPACITY)))
    else $error("full reported below capacity");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STAT_EMPTY) |-> (m_tdata[126:120] == '0))
    else $error("empty reported with records held");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[126:120] <= COUNT_W'(CAPACITY)) && !m_tdata[127])
    else $error("count beyond capacity");

endmodule

bind keyed_record_table_unit krt_checker #(.CAPACITY(CAPACITY)) u_krt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
